FILE: rtl/slek_pkg.sv
// Shared constants, codes and control structs of the envelope kernel builder.
package slek_pkg;

  localparam int unsigned KERNEL_DEPTH = 1024;
  localparam int unsigned AW = $clog2(KERNEL_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = 16;
  localparam int unsigned FW = 11;
  localparam int unsigned VW = 16;
  localparam int unsigned PW = 32;
  localparam int unsigned NW = 43;
  localparam int unsigned DW = 28;
  localparam int unsigned QW = 17;

  localparam logic [FW-1:0] FADE_RST  = 11'd40;
  localparam logic [VW-1:0] SLIDE_RST = 16'd1;

  localparam logic CFG_FADE  = 1'b0;
  localparam logic CFG_SLIDE = 1'b1;
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_EMIT  = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear;
    logic div_load;
    logic lvl_upd;
    logic mul_src;
    logic store;
    logic finish;
    logic rd;
    logic mul_fade;
    logic mul_den;
    logic div_emit;
    logic out_load;
  } slek_cmd_t;

  typedef struct packed {
    logic kernel_ready;
    logic full;
    logic div_done;
  } slek_sts_t;

endpackage

FILE: rtl/slek_div.sv
// Restoring divider, one quotient bit per cycle, saturating on overflow.
module slek_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [slek_pkg::NW-1:0]   num_i,
  input  logic [slek_pkg::DW-1:0]   den_i,
  output logic                      done_o,
  output logic [slek_pkg::QW-1:0]   quot_o
);
  import slek_pkg::*;

  localparam int unsigned OW   = DW + QW;
  localparam int unsigned SHW  = DW + QW - 1;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   rem_q;
  logic [SHW-1:0]  dsh_q;
  logic [QW-1:0]   quot_q;
  logic            ovf, ge;
  logic [SHW-1:0]  diff;

  assign ovf  = OW'(num_i) >= {den_i, {QW{1'b0}}};
  assign ge   = SHW'(rem_q) >= dsh_q;
  assign diff = SHW'(rem_q) - dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ovf) begin
          quot_q <= '1;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          rem_q  <= num_i;
          dsh_q  <= {den_i, {(QW-1){1'b0}}};
          quot_q <= '0;
          cnt_q  <= CNTW'(QW);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= diff[NW-1:0];
        end
        quot_q <= {quot_q[QW-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        cnt_q  <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/slek_ctrl.sv
// Sequencer for the load and emit operations of the kernel builder.
module slek_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  slek_pkg::slek_sts_t sts_i,
  output slek_pkg::slek_cmd_t cmd_o
);
  import slek_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LSTART, S_LDIV, S_LMUL, S_LSTORE, S_LFIN,
    S_ERD, S_EMUL1, S_EMUL2, S_EDIVST, S_EDIV, S_EOUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (action_i == ACT_LOAD) begin
            cmd_o.clear = sts_i.kernel_ready;
            state_d     = S_LSTART;
          end else if (sts_i.kernel_ready) begin
            state_d = S_ERD;
          end
        end
      end
      S_LSTART: begin
        if (sts_i.full) begin
          state_d = S_LFIN;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_LDIV;
        end
      end
      S_LDIV: begin
        if (sts_i.div_done) begin
          cmd_o.lvl_upd = 1'b1;
          state_d       = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd_o.mul_src = 1'b1;
        state_d       = S_LSTORE;
      end
      S_LSTORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_LFIN;
      end
      S_LFIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_ERD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMUL1;
      end
      S_EMUL1: begin
        cmd_o.mul_fade = 1'b1;
        state_d        = S_EMUL2;
      end
      S_EMUL2: begin
        cmd_o.mul_den = 1'b1;
        state_d       = S_EDIVST;
      end
      S_EDIVST: begin
        cmd_o.div_emit = 1'b1;
        state_d        = S_EDIV;
      end
      S_EDIV: begin
        if (sts_i.div_done) begin
          state_d = S_EOUT;
        end
      end
      S_EOUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/slek_dp.sv
// Datapath: follower, peak, kernel memory, shared multiplier and divider.
module slek_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slek_pkg::slek_cmd_t        cmd_i,
  output slek_pkg::slek_sts_t        sts_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [slek_pkg::VW-1:0]    cfg_data_i,
  input  logic signed [slek_pkg::SW-1:0] source_sample_i,
  input  logic signed [slek_pkg::SW-1:0] window_sample_i,
  input  logic                       load_last_i,
  output logic signed [slek_pkg::SW-1:0] kernel_sample_o,
  output logic                       kernel_last_o
);
  import slek_pkg::*;

  logic [FW-1:0] fade_q;
  logic [VW-1:0] slide_q;

  logic [SW-1:0] mem [KERNEL_DEPTH];
  logic [SW-1:0] rdata_q;

  logic [SW-1:0] src_mag_q, win_mag_q, level_q, peak_q;
  logic          src_neg_q, last_q, up_q, kready_q;
  logic [CW-1:0] count_q, rd_q;
  logic [FW-1:0] num_q, den_q;
  logic [PW-1:0] prod_q;
  logic [DW-2:0] d_q;
  logic [SW-1:0] kout_q;
  logic          klast_q;

  // Shared multiplier and divider
  logic [SW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          div_start, div_done;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic [QW-1:0] quot;

  logic [VW-1:0] div_eff;
  logic [SW-1:0] gap, smag;
  logic          up;
  logic [PW-1:0] rsum;
  logic [QW-1:0] pm17;
  logic [SW-1:0] pm, sval;
  logic [FW-1:0] num_d, den_d;
  logic [SW-1:0] esat;
  logic [CW-1:0] rd_inc;

  assign div_eff = (slide_q == '0) ? VW'(1) : slide_q;
  assign up      = win_mag_q >= level_q;
  assign gap     = up ? (win_mag_q - level_q) : (level_q - win_mag_q);
  assign smag    = rdata_q[SW-1] ? (SW'(0) - rdata_q) : rdata_q;

  always_comb begin
    mul_a = src_mag_q;
    mul_b = level_q;
    if (cmd_i.mul_fade) begin
      mul_a = smag;
      mul_b = SW'(num_q);
    end else if (cmd_i.mul_den) begin
      mul_a = peak_q;
      mul_b = SW'(den_q);
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign div_start = cmd_i.div_load | cmd_i.div_emit;
  always_comb begin
    if (cmd_i.div_emit) begin
      div_num = {prod_q[NW-17:0], 16'b0} + NW'(d_q);
      div_den = {d_q, 1'b0};
    end else begin
      div_num = NW'({gap, 1'b0}) + NW'(div_eff);
      div_den = DW'({div_eff, 1'b0});
    end
  end

  slek_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Product rounding for the stored sample; the peak tracks the magnitude before the clamp to 32767.
  assign rsum = prod_q + PW'(16384);
  assign pm17 = rsum[PW-1:15];
  assign pm   = (pm17 > QW'(32768)) ? SW'(32768) : pm17[SW-1:0];
  assign sval = src_neg_q ? (SW'(0) - pm) : ((pm > SW'(32767)) ? SW'(32767) : pm);

  // Fade factor for the sample at the read index.
  always_comb begin
    num_d = FW'(1);
    den_d = FW'(1);
    if (fade_q != '0) begin
      if (FW'(rd_q) < fade_q) begin
        num_d = FW'(rd_q);
        den_d = fade_q;
      end else if (!(FW'(count_q) > fade_q && FW'(rd_q) < FW'(count_q) - fade_q)) begin
        num_d = FW'(count_q - rd_q);
        den_d = fade_q;
      end
    end
  end

  always_comb begin
    if (peak_q == '0) begin
      esat = '0;
    end else if (rdata_q[SW-1]) begin
      esat = (quot >= QW'(32768)) ? SW'(32768) : (SW'(0) - quot[SW-1:0]);
    end else begin
      esat = (quot > QW'(32767)) ? SW'(32767) : quot[SW-1:0];
    end
  end

  assign rd_inc = rd_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q   <= FADE_RST;
      slide_q  <= SLIDE_RST;
      level_q  <= '0;
      peak_q   <= '0;
      count_q  <= '0;
      rd_q     <= '0;
      kready_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FADE) begin
          fade_q <= cfg_data_i[FW-1:0];
        end else begin
          slide_q <= cfg_data_i;
        end
      end
      if (cmd_i.clear) begin
        level_q  <= '0;
        peak_q   <= '0;
        count_q  <= '0;
        rd_q     <= '0;
        kready_q <= 1'b0;
      end
      if (cmd_i.lvl_upd) begin
        level_q <= up_q ? (level_q + quot[SW-1:0]) : (level_q - quot[SW-1:0]);
      end
      if (cmd_i.store) begin
        count_q <= count_q + CW'(1);
        if (pm > peak_q) begin
          peak_q <= pm;
        end
      end
      if (cmd_i.finish && last_q && count_q != '0) begin
        kready_q <= 1'b1;
        rd_q     <= '0;
      end
      if (cmd_i.out_load) begin
        rd_q <= (rd_inc >= count_q) ? '0 : rd_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      src_neg_q <= source_sample_i[SW-1];
      src_mag_q <= source_sample_i[SW-1] ? (SW'(0) - source_sample_i) : source_sample_i;
      win_mag_q <= window_sample_i[SW-1] ? (SW'(0) - window_sample_i) : window_sample_i;
      last_q    <= load_last_i;
    end
    if (cmd_i.div_load) begin
      up_q <= up;
    end
    if (cmd_i.mul_src || cmd_i.mul_fade) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_den) begin
      d_q <= mul_p[DW-2:0];
    end
    if (cmd_i.store) begin
      mem[count_q[AW-1:0]] <= sval;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_q[AW-1:0]];
      num_q   <= num_d;
      den_q   <= den_d;
    end
    if (cmd_i.out_load) begin
      kout_q  <= esat;
      klast_q <= (rd_inc == count_q);
    end
  end

  assign sts_o.kernel_ready = kready_q;
  assign sts_o.full         = count_q >= CW'(KERNEL_DEPTH);
  assign sts_o.div_done     = div_done;

  assign kernel_sample_o = kout_q;
  assign kernel_last_o   = klast_q;

endmodule

FILE: rtl/slide_envelope_kernel_builder_core.sv
// Top level of the envelope-shaped kernel builder.
// A load request runs the shared 17-step divider, then a multiply and a store; an emit
// request reads, multiplies twice, divides and waits out any output stall. One request
// is in work at a time; a full store takes no more samples, a zero peak emits zeros.
// A result waits in the output register while the next request is accepted.
// Reset (async, active low) clears the follower, peak, count, read index and
// ready flag and sets fade_length to 40 and slide_amount to 1; memory is not cleared.
module slide_envelope_kernel_builder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [slek_pkg::VW-1:0]        cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic signed [slek_pkg::SW-1:0] source_sample_i,
  input  logic signed [slek_pkg::SW-1:0] window_sample_i,
  input  logic                           load_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [slek_pkg::SW-1:0] kernel_sample_o,
  output logic                           kernel_last_o
);
  import slek_pkg::*;

  slek_cmd_t cmd;
  slek_sts_t sts;

  assign cfg_ready_o = 1'b1;

  slek_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slek_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .source_sample_i(source_sample_i),
    .window_sample_i(window_sample_i),
    .load_last_i    (load_last_i),
    .kernel_sample_o(kernel_sample_o),
    .kernel_last_o  (kernel_last_o)
  );

endmodule

FILE: tb/slide_envelope_kernel_builder_core_test.sv
// Self-checking testbench for the envelope-shaped kernel builder core.
module slide_envelope_kernel_builder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slek_pkg::*;

  typedef struct packed {
    logic             action;
    logic signed [15:0] source;
    logic signed [15:0] window;
    logic             last;
  } request_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic             last;
  } kernel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CFG_FADE;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = ACT_LOAD;
  logic signed [15:0] source_sample_i = '0;
  logic signed [15:0] window_sample_i = '0;
  logic load_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] kernel_sample_o;
  logic kernel_last_o;

  slide_envelope_kernel_builder_core u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state.
  logic [15:0] kernel_mem [KERNEL_DEPTH];
  int unsigned follow_lvl, peak_lvl, kern_len, rd_pos;
  bit kern_done;
  int unsigned fade_cfg = 40, slide_cfg = 1;

  request_t pending_req[$];
  kernel_out_t expected_out[$];
  int unsigned sent_cnt, load_cnt, emit_cnt, checked_cnt, mismatch_cnt, cfg_cnt;
  int unsigned in_idle_pct, out_idle_pct;

  function automatic int unsigned round_div(longint unsigned n, longint unsigned d);
    return int'((n * 2 + d) / (d * 2));
  endfunction

  function automatic void predict_load(request_t r);
    int unsigned mag, dv, step, pmag, smag;
    int signed v;
    if (kern_done) begin
      kern_len = 0; follow_lvl = 0; peak_lvl = 0; rd_pos = 0; kern_done = 0;
    end
    if (kern_len < KERNEL_DEPTH) begin
      mag = r.window < 0 ? -int'(r.window) : int'(r.window);
      dv = slide_cfg == 0 ? 1 : slide_cfg;
      if (mag >= follow_lvl) begin
        step = round_div(mag - follow_lvl, dv);
        follow_lvl += step;
      end else begin
        step = round_div(follow_lvl - mag, dv);
        follow_lvl -= step;
      end
      smag = r.source < 0 ? -int'(r.source) : int'(r.source);
      pmag = int'((longint'(smag) * follow_lvl + 16384) >> 15);
      if (pmag > 32768) pmag = 32768;
      v = r.source < 0 ? -int'(pmag) : int'(pmag);
      if (v > 32767) v = 32767;
      kernel_mem[kern_len] = v[15:0];
      if (pmag > peak_lvl) peak_lvl = pmag;
      kern_len++;
    end
    if (r.last && kern_len > 0) begin
      kern_done = 1; rd_pos = 0;
    end
  endfunction

  function automatic void predict_emit();
    kernel_out_t o;
    int signed s;
    longint unsigned num, den, mg, d, q;
    int unsigned i;
    if (!kern_done || kern_len == 0) return;
    if (rd_pos >= kern_len) rd_pos = 0;
    i = rd_pos;
    s = $signed(kernel_mem[i]);
    num = 1; den = 1;
    if (peak_lvl == 0) begin
      o.sample = '0;
    end else begin
      if (fade_cfg != 0) begin
        if (i < fade_cfg) begin
          num = i; den = fade_cfg;
        end else if (!(kern_len > fade_cfg && i < kern_len - fade_cfg)) begin
          num = kern_len - i; den = fade_cfg;
        end
      end
      mg = longint'(s < 0 ? -s : s) * 32768 * num;
      d = longint'(peak_lvl) * den;
      q = (mg * 2 + d) / (d * 2);
      if (s < 0) o.sample = q >= 32768 ? -16'sd32768 : -$signed(q[15:0]);
      else o.sample = q > 32767 ? 16'sd32767 : q[15:0];
    end
    o.last = (i + 1 == kern_len);
    rd_pos = (i + 1 >= kern_len) ? 0 : i + 1;
    expected_out.push_back(o);
  endfunction

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) sent_cnt++;
        if (pending_req.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          request_t r;
          r = pending_req.pop_front();
          if (r.action == ACT_LOAD) begin
            predict_load(r); load_cnt++;
          end else begin
            predict_emit(); emit_cnt++;
          end
          action_i <= r.action;
          source_sample_i <= r.source;
          window_sample_i <= r.window;
          load_last_i <= r.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      kernel_out_t e;
      if (expected_out.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result %0d", kernel_sample_o);
      end else begin
        e = expected_out.pop_front();
        checked_cnt++;
        if (kernel_sample_o !== e.sample || kernel_last_o !== e.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch at result %0d: expected sample %0d last %0b, got %0d last %0b",
                     checked_cnt, e.sample, e.last, kernel_sample_o, kernel_last_o);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FADE) fade_cfg = val[10:0];
    else slide_cfg = val;
    cfg_cnt++;
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || in_valid_i || expected_out.size() > 0)
      @(posedge clk_i);
    // A trailing load leaves no result but may still be in work.
    repeat (60) @(posedge clk_i);
  endtask

  function automatic void queue_kernel(int unsigned len, int unsigned emits, bit noisy);
    request_t r;
    for (int unsigned k = 0; k < len; k++) begin
      r.action = ACT_LOAD;
      r.source = 16'($urandom);
      r.window = ($urandom_range(3) == 0) ? 16'sh8000 : 16'($urandom);
      r.last = (k == len - 1) || (noisy && $urandom_range(40) == 0);
      pending_req.push_back(r);
    end
    for (int unsigned k = 0; k < emits; k++) begin
      r = '0; r.action = ACT_EMIT; r.source = 16'($urandom); r.window = 16'($urandom);
      r.last = 1'($urandom);
      pending_req.push_back(r);
    end
  endfunction

  function automatic void queue_random(int unsigned total);
    int unsigned n;
    n = 0;
    while (n < total) begin
      int unsigned len, em;
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
      em = $urandom_range(0, len + 3);
      queue_kernel(len, em, $urandom_range(9) == 0);
      n += len + em;
    end
  endfunction

  initial begin
    request_t r;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Emit before any kernel: nothing comes back.
    r = '0; r.action = ACT_EMIT; pending_req.push_back(r);
    // Extremes of fields and the zero-peak kernel.
    r = '{ACT_LOAD, 16'sh7fff, 16'sh8000, 1'b0}; pending_req.push_back(r);
    r = '{ACT_LOAD, 16'sh8000, 16'sh7fff, 1'b0}; pending_req.push_back(r);
    r = '{ACT_LOAD, 16'sh8000, 16'sh8000, 1'b0}; pending_req.push_back(r);
    r = '{ACT_LOAD, 16'sh0001, 16'shffff, 1'b1}; pending_req.push_back(r);
    r = '{ACT_EMIT, 16'sh0, 16'sh0, 1'b0};
    repeat (6) pending_req.push_back(r);
    r = '{ACT_LOAD, 16'sh1234, 16'sh0000, 1'b0}; pending_req.push_back(r);
    r = '{ACT_LOAD, 16'sh0000, 16'sh7fff, 1'b1}; pending_req.push_back(r);
    r = '{ACT_EMIT, 16'sh0, 16'sh0, 1'b1};
    repeat (3) pending_req.push_back(r);
    drain();

    // No fade, slowest follower.
    write_reg(CFG_FADE, 16'd0);
    write_reg(CFG_SLIDE, 16'd65535);
    queue_kernel(8, 9, 0);
    drain();
    // Slide of zero acts as one; fade longer than the kernel.
    write_reg(CFG_SLIDE, 16'd0);
    write_reg(CFG_FADE, 16'd1024);
    queue_kernel(5, 6, 0);
    drain();
    // Register bits above the fade width are dropped.
    write_reg(CFG_FADE, 16'hffff);
    queue_kernel(3, 3, 0);
    drain();

    // Store full: the loads past the depth are dropped, then six emits read from the start.
    write_reg(CFG_FADE, 16'd3);
    write_reg(CFG_SLIDE, 16'd2);
    queue_kernel(KERNEL_DEPTH + 4, 6, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = ph == 0 ? 33 : ph == 1 ? 85 : 0;
      out_idle_pct = ph == 0 ? 85 : ph == 1 ? 33 : 0;
      write_reg(CFG_FADE, 16'($urandom_range(0, 6)));
      write_reg(CFG_SLIDE, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)));
      queue_random(150);
      drain();
    end

    $display("Covered %0d loads and %0d emits with %0d register writes; %0d results checked.",
             load_cnt, emit_cnt, cfg_cnt, checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: files.f
rtl/slek_pkg.sv
rtl/slek_div.sv
rtl/slek_ctrl.sv
rtl/slek_dp.sv
rtl/slide_envelope_kernel_builder_core.sv
tb/slide_envelope_kernel_builder_core_test.sv
